FILE: rtl/core/sbt_pkg.sv
package sbt_pkg;

  // Size of the source text; offsets saturate at the lesser of this minus one and 16 bits.
  localparam longint unsigned SOURCE_BYTES = 64'd65536;
  localparam logic [15:0] POS_LIMIT =
    (SOURCE_BYTES - 64'd1 > 64'd65535) ? 16'hFFFF : 16'(SOURCE_BYTES - 64'd1);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_VT         = 8'h0B;
  localparam logic [7:0] CH_FF         = 8'h0C;
  localparam logic [7:0] CH_LOWER_P    = 8'h70;
  localparam logic [7:0] CH_LOWER_T    = 8'h74;

  typedef enum logic [2:0] {
    TK_END     = 3'd0,
    TK_NEWLINE = 3'd1,
    TK_NUMBER  = 3'd2,
    TK_STRING  = 3'd3,
    TK_PRINT   = 3'd4,
    TK_THEN    = 3'd5,
    TK_ERROR   = 3'd6
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNTERMINATED = 2'd1,
    ERR_UNKNOWN_ID   = 2'd2,
    ERR_UNEXPECTED   = 2'd3
  } err_code_t;

  typedef enum logic [3:0] {
    MODE_IDLE  = 4'b0001,
    MODE_NUM   = 4'b0010,
    MODE_IDENT = 4'b0100,
    MODE_STR   = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_beat_t;

  typedef struct packed {
    tok_kind_t   token_kind;
    err_code_t   error_code;
    logic [15:0] span_start;
    logic [15:0] span_length;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last;
  } tok_beat_t;

  function automatic logic [7:0] kw_print_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h70; // p
      3'd1:    c = 8'h72; // r
      3'd2:    c = 8'h69; // i
      3'd3:    c = 8'h6E; // n
      3'd4:    c = 8'h74; // t
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] kw_then_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h74; // t
      2'd1: c = 8'h68; // h
      2'd2: c = 8'h65; // e
      2'd3: c = 8'h6E; // n
    endcase
    return c;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

FILE: rtl/core/source_byte_tokenizer_top.sv
// Streaming lexical scanner: one source byte in per beat, tokens out.
// Input channel in_valid/in_stall/in_data carries a source byte or the end
// marker; output channel out_valid/out_stall/out_data carries one token per
// beat, with last set on the final token caused by an input beat.
// A beat is taken at a rising edge with valid high and stall low.
// Scan state and counters update at the input edge; the tokens that beat
// causes (zero, one or two) are written into a 4-entry output queue in the
// same edge, so the first token is on out_valid in the cycle after the input.
// Throughput: one input beat per cycle while the output side keeps up; the
// single output beat per cycle sets the limit when bytes give two tokens.
// in_stall is high while fewer than two queue entries are free, so a beat
// that yields two tokens always fits. A stalled receiver holds the queue
// head steady; the input stalls once three or more tokens wait.
// Reset (rst_n low, synchronous) empties the queue and returns the scanner
// to idle: offset 0, line 1, column 1. The end marker returns the scanner
// to that state after emitting any pending token and the end token.
module source_byte_tokenizer_top
  import sbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output tok_beat_t out_data
);

  // scanner state
  scan_mode_t  mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] tsp_r, tsp_nxt;   // token start offset
  logic [15:0] tsc_r, tsc_nxt;   // token start column
  logic [1:0]  kmf_r, kmf_nxt;   // bit0 still "print", bit1 still "then"

  // output queue
  tok_beat_t            fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]   count_r;

  logic        in_acc, out_acc;
  logic [7:0]  b;
  logic        cls_digit, is_alpha, cls_word_head, cls_word, is_blank;
  logic [15:0] span_c, pos_step, col_step, line_step, str_col, str_content;
  tok_beat_t   ident_tok;
  logic        have_a, have_b, scan_b;
  tok_beat_t   tok_a, tok_b, slot0, slot1;
  logic [1:0]  res_n;

  function automatic tok_beat_t mk_tok(input tok_kind_t k, input err_code_t e,
                                       input logic [15:0] start, input logic [15:0] len,
                                       input logic [15:0] line, input logic [15:0] col);
    tok_beat_t t;
    t.token_kind    = k;
    t.error_code    = e;
    t.span_start    = start;
    t.span_length   = len;
    t.line_number   = line;
    t.column_number = col;
    t.last          = 1'b0;
    return t;
  endfunction

  assign in_stall  = (count_r > FIFO_CW'(FIFO_DEPTH - 2));
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_acc   = out_valid && !out_stall;
  assign out_data  = fifo_q[rd_ptr_r];

  // byte classes
  assign b             = in_data.source_byte;
  assign cls_digit     = (b >= 8'h30) && (b <= 8'h39);
  assign is_alpha      = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  assign cls_word_head = is_alpha || (b == CH_UNDERSCORE);
  assign cls_word      = cls_word_head || cls_digit;
  assign is_blank      = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
                         (b == CH_VT) || (b == CH_FF);

  // counter helpers, all from the registered state
  assign span_c      = (pos_r > tsp_r) ? pos_r - tsp_r : 16'd0;
  assign pos_step    = (pos_r < POS_LIMIT) ? pos_r + 16'd1 : pos_r;
  assign col_step    = sat_inc16(col_r);
  assign line_step   = sat_inc16(line_r);
  assign str_col     = (col_r > span_c) ? col_r - span_c : 16'd0;
  assign str_content = (span_c > 16'd1) ? span_c - 16'd1 : 16'd0;

  always_comb begin
    if (span_c == 16'd5 && kmf_r[0]) begin
      ident_tok = mk_tok(TK_PRINT, ERR_NONE, tsp_r, span_c, line_r, tsc_r);
    end else if (span_c == 16'd4 && kmf_r[1]) begin
      ident_tok = mk_tok(TK_THEN, ERR_NONE, tsp_r, span_c, line_r, tsc_r);
    end else begin
      ident_tok = mk_tok(TK_ERROR, ERR_UNKNOWN_ID, tsp_r, span_c, line_r, tsc_r);
    end
  end

  // Token a ends a pending token; token b comes from the idle scan or the end marker.
  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    col_nxt  = col_r;
    tsp_nxt  = tsp_r;
    tsc_nxt  = tsc_r;
    kmf_nxt  = kmf_r;
    have_a   = 1'b0;
    have_b   = 1'b0;
    scan_b   = 1'b0;
    tok_a    = '0;
    tok_b    = '0;

    if (in_data.end_of_input) begin
      unique case (mode_r)
        MODE_NUM: begin
          have_a = 1'b1;
          tok_a  = mk_tok(TK_NUMBER, ERR_NONE, tsp_r, span_c, line_r, tsc_r);
        end
        MODE_IDENT: begin
          have_a = 1'b1;
          tok_a  = ident_tok;
        end
        MODE_STR: begin
          have_a = 1'b1;
          tok_a  = mk_tok(TK_ERROR, ERR_UNTERMINATED, tsp_r, span_c, line_r, str_col);
        end
        default: begin
        end
      endcase
      have_b   = 1'b1;
      tok_b    = mk_tok(TK_END, ERR_NONE, pos_r, 16'd0, line_r, col_r);
      mode_nxt = MODE_IDLE;
      pos_nxt  = 16'd0;
      line_nxt = 16'd1;
      col_nxt  = 16'd1;
      tsp_nxt  = 16'd0;
      tsc_nxt  = 16'd0;
      kmf_nxt  = 2'b11;
    end else begin
      unique case (mode_r)
        MODE_STR: begin
          pos_nxt = pos_step;
          col_nxt = col_step;
          if (b == CH_QUOTE) begin
            have_a   = 1'b1;
            tok_a    = mk_tok(TK_STRING, ERR_NONE, tsp_r + 16'd1, str_content,
                              line_r, tsc_r);
            mode_nxt = MODE_IDLE;
          end else if (b == CH_NEWLINE) begin
            line_nxt = line_step;
            col_nxt  = 16'd1;
          end
        end
        MODE_NUM: begin
          if (cls_digit) begin
            pos_nxt = pos_step;
            col_nxt = col_step;
          end else begin
            have_a   = 1'b1;
            tok_a    = mk_tok(TK_NUMBER, ERR_NONE, tsp_r, span_c, line_r, tsc_r);
            mode_nxt = MODE_IDLE;
            scan_b   = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (cls_word) begin
            kmf_nxt[0] = kmf_r[0] && (span_c < 16'd5) && (b == kw_print_char(span_c[2:0]));
            kmf_nxt[1] = kmf_r[1] && (span_c < 16'd4) && (b == kw_then_char(span_c[1:0]));
            pos_nxt    = pos_step;
            col_nxt    = col_step;
          end else begin
            have_a   = 1'b1;
            tok_a    = ident_tok;
            mode_nxt = MODE_IDLE;
            scan_b   = 1'b1;
          end
        end
        default: begin
          scan_b = 1'b1;
        end
      endcase

      // closing a number or identifier leaves counters alone, so the idle
      // scan works from the registered values
      if (scan_b) begin
        pos_nxt = pos_step;
        col_nxt = col_step;
        if (!is_blank) begin
          tsp_nxt = pos_r;
          tsc_nxt = col_r;
          priority if (b == CH_NEWLINE) begin
            line_nxt = line_step;
            col_nxt  = 16'd1;
            have_b   = 1'b1;
            tok_b    = mk_tok(TK_NEWLINE, ERR_NONE, pos_r, 16'd1, line_step, 16'd0);
          end else if (b == CH_QUOTE) begin
            mode_nxt = MODE_STR;
          end else if (cls_digit) begin
            mode_nxt = MODE_NUM;
          end else if (cls_word_head) begin
            kmf_nxt  = {b == CH_LOWER_T, b == CH_LOWER_P};
            mode_nxt = MODE_IDENT;
          end else begin
            have_b = 1'b1;
            tok_b  = mk_tok(TK_ERROR, ERR_UNEXPECTED, pos_r, 16'd1, line_r, col_r);
          end
        end
      end
    end
  end

  // pack results in order, mark the final one
  always_comb begin
    res_n      = {1'b0, have_a} + {1'b0, have_b};
    slot0      = have_a ? tok_a : tok_b;
    slot1      = tok_b;
    slot0.last = (res_n == 2'd1);
    slot1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= 16'd0;
      line_r <= 16'd1;
      col_r  <= 16'd1;
      tsp_r  <= 16'd0;
      tsc_r  <= 16'd0;
      kmf_r  <= 2'b11;
    end else if (in_acc) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      tsp_r  <= tsp_nxt;
      tsc_r  <= tsc_nxt;
      kmf_r  <= kmf_nxt;
    end
  end

  // queue storage, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc && res_n != 2'd0) begin
      fifo_q[wr_ptr_r] <= slot0;
    end
    if (in_acc && res_n == 2'd2) begin
      fifo_q[wr_ptr_r + FIFO_AW'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(res_n);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      count_r <= count_r + (in_acc ? FIFO_CW'(res_n) : FIFO_CW'(0))
                         - (out_acc ? FIFO_CW'(1) : FIFO_CW'(0));
    end
  end

  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("output queue overflow");

  // end marker returns scanner to its start state
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.end_of_input) |=>
      (mode_r == MODE_IDLE && pos_r == 16'd0 && line_r == 16'd1 && col_r == 16'd1))
    else $error("scanner not reset after end marker");

  // inside an identifier at most one keyword can still match
  a_kw_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDENT) |-> (kmf_r != 2'b11))
    else $error("both keyword flags set inside identifier");

  // line and column counters start at one and never wrap
  a_line_col: assert property (@(posedge clk) disable iff (!rst_n)
    (line_r != 16'd0) && (col_r != 16'd0))
    else $error("line or column counter reached zero");

endmodule

FILE: tb/source_byte_tokenizer_top_tb.sv
// Token stream check for the source byte tokenizer.
// Byte texts go in one beat per byte, each closed by an end-marker beat.
// Every accepted input beat is run through a local scanner model and the
// tokens it should cause are queued; every accepted output beat is checked
// against the oldest queued token.
module source_byte_tokenizer_top_tb;
  import sbt_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // ---------------------------------------------------------------------
  // Scanner model and token scoreboard
  // ---------------------------------------------------------------------
  class token_scoreboard;
    tok_beat_t  expected_q[$];
    tok_beat_t  fresh[$];
    int         errors = 0;

    scan_mode_t  mode;
    logic [15:0] pos;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    logic [15:0] tok_pos;
    logic [15:0] tok_col;
    logic [1:0]  kw_hits;   // bit0 still "print", bit1 still "then"
    string       print_txt = "print";
    string       then_txt  = "then";

    function new();
      restart();
    endfunction

    function void restart();
      mode     = MODE_IDLE;
      pos      = 16'd0;
      cur_line = 16'd1;
      cur_col  = 16'd1;
      tok_pos  = 16'd0;
      tok_col  = 16'd0;
      kw_hits  = 2'b11;
    endfunction

    function void advance();
      if (pos < POS_LIMIT) pos++;
      if (cur_col != 16'hFFFF) cur_col++;
    endfunction

    function void next_line();
      if (cur_line != 16'hFFFF) cur_line++;
      cur_col = 16'd1;
    endfunction

    function logic [15:0] span_from_start();
      return (pos > tok_pos) ? pos - tok_pos : 16'd0;
    endfunction

    function bit digit_byte(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_word_head(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDERSCORE;
    endfunction

    function void emit(tok_kind_t k, err_code_t e, logic [15:0] s, logic [15:0] n,
                       logic [15:0] ln, logic [15:0] c);
      tok_beat_t t;
      t.token_kind    = k;
      t.error_code    = e;
      t.span_start    = s;
      t.span_length   = n;
      t.line_number   = ln;
      t.column_number = c;
      t.last          = 1'b0;
      fresh.push_back(t);
    endfunction

    function void close_number();
      emit(TK_NUMBER, ERR_NONE, tok_pos, span_from_start(), cur_line, tok_col);
      mode = MODE_IDLE;
    endfunction

    function void close_word();
      logic [15:0] len;
      len = span_from_start();
      if (len == 16'd5 && kw_hits[0])
        emit(TK_PRINT, ERR_NONE, tok_pos, len, cur_line, tok_col);
      else if (len == 16'd4 && kw_hits[1])
        emit(TK_THEN, ERR_NONE, tok_pos, len, cur_line, tok_col);
      else
        emit(TK_ERROR, ERR_UNKNOWN_ID, tok_pos, len, cur_line, tok_col);
      mode = MODE_IDLE;
    endfunction

    // Byte seen between tokens.
    function void scan_between(logic [7:0] b);
      if (b inside {CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF}) begin
        advance();
        return;
      end
      tok_pos = pos;
      tok_col = cur_col;
      if (b == CH_NEWLINE) begin
        advance();
        next_line();
        emit(TK_NEWLINE, ERR_NONE, tok_pos, 16'd1, cur_line, 16'd0);
      end else if (b == CH_QUOTE) begin
        advance();
        mode = MODE_STR;
      end else if (digit_byte(b)) begin
        advance();
        mode = MODE_NUM;
      end else if (is_word_head(b)) begin
        kw_hits = {b == CH_LOWER_T, b == CH_LOWER_P};
        advance();
        mode = MODE_IDENT;
      end else begin
        emit(TK_ERROR, ERR_UNEXPECTED, pos, 16'd1, cur_line, cur_col);
        advance();
      end
    endfunction

    function void note_beat(in_beat_t beat);
      logic [7:0]  b;
      logic [15:0] len;
      logic [1:0]  hits;
      b = beat.source_byte;
      fresh.delete();
      if (beat.end_of_input) begin
        if (mode == MODE_NUM) begin
          close_number();
        end else if (mode == MODE_IDENT) begin
          close_word();
        end else if (mode == MODE_STR) begin
          len = span_from_start();
          emit(TK_ERROR, ERR_UNTERMINATED, tok_pos, len, cur_line,
               (cur_col > len) ? cur_col - len : 16'd0);
        end
        emit(TK_END, ERR_NONE, pos, 16'd0, cur_line, cur_col);
        restart();
      end else if (mode == MODE_STR) begin
        if (b == CH_QUOTE) begin
          len = span_from_start();
          advance();
          emit(TK_STRING, ERR_NONE, tok_pos + 16'd1, (len > 16'd1) ? len - 16'd1 : 16'd0,
               cur_line, tok_col);
          mode = MODE_IDLE;
        end else begin
          advance();
          if (b == CH_NEWLINE) next_line();
        end
      end else if (mode == MODE_NUM) begin
        if (digit_byte(b)) begin
          advance();
        end else begin
          close_number();
          scan_between(b);
        end
      end else if (mode == MODE_IDENT) begin
        if (is_word_head(b) || digit_byte(b)) begin
          len  = span_from_start();
          hits = 2'b00;
          if (kw_hits[0] && len < 16'd5 && b == print_txt[len]) hits[0] = 1'b1;
          if (kw_hits[1] && len < 16'd4 && b == then_txt[len]) hits[1] = 1'b1;
          kw_hits = hits;
          advance();
        end else begin
          close_word();
          scan_between(b);
        end
      end else begin
        scan_between(b);
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) expected_q.push_back(fresh[i]);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    endfunction

    function void check_beat(tok_beat_t got);
      tok_beat_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: token with nothing expected, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
      compare_field("error_code", 16'(want.error_code), 16'(got.error_code));
      compare_field("span_start", want.span_start, got.span_start);
      compare_field("span_length", want.span_length, got.span_length);
      compare_field("line_number", want.line_number, got.line_number);
      compare_field("column_number", want.column_number, got.column_number);
      compare_field("last", 16'(want.last), 16'(got.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------
  // Clock, reset and the block
  // ---------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tok_beat_t out_data;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  source_byte_tokenizer_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  token_scoreboard sb;

  // Idle controls: sender gaps, receiver stall bursts, one long hold-off.
  bit sender_idle  = 1'b1;
  bit recv_idle    = 1'b1;
  bit hold_request = 1'b0;

  // Text being built for the next send.
  byte_q_t text_buf;
  int      random_beats;
  int      drain;

  logic [7:0] blank_set [5] = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF};
  // Words that sit close to the keywords without being one.
  string near_miss [12] = '{"prin", "printx", "the", "thenn", "Print", "THEN",
                            "then_", "_p9", "t", "p", "print9", "pr1nt"};

  // ---------------------------------------------------------------------
  // Beat monitor: both channels sampled at the rising edge. The output is
  // checked first; a token can never come from the input beat of the same
  // edge, so the order only keeps the code easy to follow.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_beat(out_data);
      if (in_valid === 1'b1 && in_stall === 1'b0) sb.note_beat(in_data);
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request so the
  // output queue fills and the block has to stall its input.
  // ---------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
      end else if (recv_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender side. Called at a falling edge, returns at a falling edge after
  // the beat was taken. valid is only touched once per falling edge.
  // ---------------------------------------------------------------------
  task automatic send_beat(input in_beat_t beat);
    int gap;
    if (sender_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends text_buf byte by byte, then the end marker with a junk byte.
  task automatic send_text();
    in_beat_t beat;
    foreach (text_buf[i]) begin
      beat.source_byte  = text_buf[i];
      beat.end_of_input = 1'b0;
      send_beat(beat);
    end
    beat.source_byte  = 8'($urandom_range(0, 255));
    beat.end_of_input = 1'b1;
    send_beat(beat);
    text_buf.delete();
  endtask

  function automatic void add_str(string s);
    foreach (s[i]) text_buf.push_back(s[i]);
  endfunction

  // Letter, underscore or (for a tail) digit.
  function automatic logic [7:0] word_char(bit head);
    int r;
    r = $urandom_range(0, head ? 52 : 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return CH_UNDERSCORE;
    return 8'h30 + 8'(r - 53);
  endfunction

  // String content: letters, newlines and any byte but the quote.
  function automatic void add_quoted_body();
    logic [7:0] c;
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 3))
        0: c = CH_NEWLINE;
        1: begin
          do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
        end
        default: c = word_char(1'b1);
      endcase
      text_buf.push_back(c);
    end
  endfunction

  // One lexeme, mostly well formed, some noise.
  function automatic void add_piece();
    case ($urandom_range(0, 11))
      0, 10: add_str("print");
      1, 11: add_str("then");
      2: add_str(near_miss[$urandom_range(0, 11)]);
      3: begin
        case ($urandom_range(0, 2))
          0: text_buf.push_back(CH_LOWER_P);
          1: text_buf.push_back(CH_LOWER_T);
          default: text_buf.push_back(word_char(1'b1));
        endcase
        repeat ($urandom_range(0, 6)) text_buf.push_back(word_char(1'b0));
      end
      4: repeat ($urandom_range(1, 5)) text_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
      5: begin
        text_buf.push_back(CH_QUOTE);
        add_quoted_body();
        text_buf.push_back(CH_QUOTE);
      end
      6: repeat ($urandom_range(1, 3)) text_buf.push_back(blank_set[$urandom_range(0, 4)]);
      7: text_buf.push_back(CH_NEWLINE);
      8: text_buf.push_back(8'($urandom_range(0, 255)));
      default: begin
        case ($urandom_range(0, 2))
          0: text_buf.push_back(8'h00);
          1: text_buf.push_back(8'($urandom_range(128, 255)));
          default: text_buf.push_back(8'h2B);
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: both keywords, number running into a string, a string over
    // a newline, zero and 0xFF bytes, newline token, CR and VT blanks.
    add_str("print");
    text_buf.push_back(CH_CR);
    add_str("then");
    text_buf.push_back(CH_VT);
    add_str("9");
    text_buf.push_back(CH_QUOTE);
    add_str("a");
    text_buf.push_back(CH_NEWLINE);
    text_buf.push_back(CH_QUOTE);
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hFF);
    text_buf.push_back(CH_NEWLINE);
    send_text();
    // Identifier with a digit tail, then a string left open at the end.
    text_buf.push_back(CH_FF);
    add_str("_7");
    text_buf.push_back(CH_TAB);
    text_buf.push_back(CH_QUOTE);
    add_str("q");
    send_text();

    // Random texts; the receiver holds off once early on.
    hold_request = 1'b1;
    random_beats = 0;
    while (random_beats < 750) begin
      if ($urandom_range(0, 9) != 0) begin
        repeat ($urandom_range(1, 12)) begin
          add_piece();
          if ($urandom_range(0, 1) == 0) text_buf.push_back(CH_SPACE);
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        text_buf.push_back(CH_QUOTE);
        add_quoted_body();
      end
      random_beats += text_buf.size() + 1;
      sender_idle = ($urandom_range(0, 3) != 0);
      send_text();
    end

    // Last part, no idling: a short text back to back, then another to see
    // that the end marker brought everything back.
    sender_idle = 1'b0;
    recv_idle   = 1'b0;
    add_str("print");
    add_str("42");
    text_buf.push_back(CH_NEWLINE);
    add_str("7");
    text_buf.push_back(CH_SPACE);
    text_buf.push_back(CH_QUOTE);
    add_str("ab");
    send_text();
    add_str("then 5");
    send_text();
    in_valid <= 1'b0;

    // Wait for the queue to drain, then wait on for strays.
    drain = 0;
    while (sb.pending() != 0 && drain < 10000) begin
      @(negedge clk);
      drain++;
    end
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d expected tokens never arrived", $time, sb.pending());
    end
    repeat (20) @(negedge clk);

    if (sb.errors == 0) begin
      $display("source_byte_tokenizer_top_tb: done, clean");
    end else begin
      $display("source_byte_tokenizer_top_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("source_byte_tokenizer_top_tb: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sbt_pkg.sv
rtl/core/source_byte_tokenizer_top.sv
tb/source_byte_tokenizer_top_tb.sv
